FILE: sv/qos_inflight_retry_tracker_assert.svh
// ---------------------------------------------------------------------------
// qos_inflight_retry_tracker_assert.svh
// assertion macros shared by the tracker modules
// ---------------------------------------------------------------------------
`ifndef QOS_INFLIGHT_RETRY_TRACKER_ASSERT_SVH
`define QOS_INFLIGHT_RETRY_TRACKER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define QIRT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define QIRT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/qirt_pkg.sv
// ---------------------------------------------------------------------------
// qirt_pkg
// types and constants of the qos in-flight retry tracker
// ---------------------------------------------------------------------------
package qirt_pkg;

    localparam int SLOTS     = 8;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    // commands
    localparam logic [2:0] CMD_RECORD  = 3'd0;
    localparam logic [2:0] CMD_PUBACK  = 3'd1;
    localparam logic [2:0] CMD_PUBREC  = 3'd2;
    localparam logic [2:0] CMD_PUBCOMP = 3'd3;
    localparam logic [2:0] CMD_PUBREL  = 3'd4;
    localparam logic [2:0] CMD_TICK    = 3'd5;

    // actions
    localparam logic [2:0] ACT_PUBLISH = 3'd0;
    localparam logic [2:0] ACT_PUBREL  = 3'd1;
    localparam logic [2:0] ACT_PUBCOMP = 3'd2;
    localparam logic [2:0] ACT_GAVE_UP = 3'd3;
    localparam logic [2:0] ACT_FULL    = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES    = 1'd1;

    localparam logic [15:0] RESET_INTERVAL = 16'd100;
    localparam logic [3:0]  RESET_RETRIES  = 4'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] message_id;
        logic [15:0] topic;
        logic [1:0]  qos_level;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] out_message_id;
        logic [15:0] out_topic;
        logic [1:0]  out_qos;
        logic [2:0]  slot_index;
        logic        last;
    } t_out_item;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic start;
        logic step;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic scan_done;
    } t_sts;

endpackage

FILE: sv/qirt_ctrl.sv
// ---------------------------------------------------------------------------
// qirt_ctrl
// controller: accepts commands and sequences the tick scan
// ---------------------------------------------------------------------------
module qirt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [2:0]    i_cmd,
    input  qirt_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output qirt_pkg::t_ctl o_ctl
);
    import qirt_pkg::*;

`include "qos_inflight_retry_tracker_assert.svh"

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_ctl      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = !i_sts.out_free;
                if (i_in_valid && i_sts.out_free) begin
                    if (i_cmd == CMD_TICK) begin
                        o_ctl.start = 1'b1;
                        n_state     = ST_SCAN;
                    end else begin
                        o_ctl.exec = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                o_ctl.step = i_sts.out_free;
                if (i_sts.out_free && i_sts.scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `QIRT_ASSERT_NXT(a_scan_ends, o_ctl.step && i_sts.scan_done, r_state == ST_IDLE, "scan did not end")
    `QIRT_ASSERT_NXT(a_tick_scans, o_ctl.start, r_state == ST_SCAN, "tick did not start a scan")
    `QIRT_ASSERT_IMP(a_one_cmd, o_ctl.exec || o_ctl.start, !o_ctl.step, "command during scan")

endmodule

FILE: sv/qirt_dp.sv
// ---------------------------------------------------------------------------
// qirt_dp
// datapath: slot table, scan counter, config registers, result register
// ---------------------------------------------------------------------------
module qirt_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qirt_pkg::t_ctl                i_ctl,
    output qirt_pkg::t_sts                o_sts,
    input  qirt_pkg::t_in_item            i_in_data,
    input  logic                          i_cfg_we,
    input  logic [qirt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [qirt_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output qirt_pkg::t_out_item           o_out_data
);
    import qirt_pkg::*;

`include "qos_inflight_retry_tracker_assert.svh"

    logic [15:0]       r_interval;
    logic [3:0]        r_max_retries;
    logic [SLOTS-1:0]  r_valid;
    logic [15:0]       r_id      [SLOTS];
    logic [15:0]       r_topic   [SLOTS];
    logic [1:0]        r_qos     [SLOTS];
    logic              r_step    [SLOTS];
    logic [3:0]        r_retries [SLOTS];
    logic [15:0]       r_age     [SLOTS];
    logic [SLOT_W-1:0] r_idx;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [15:0]       age_inc [SLOTS];
    logic [SLOTS-1:0]  fire;
    logic              later_fire;
    logic              m_found;
    logic [SLOT_W-1:0] m_idx;
    logic              f_found;
    logic [SLOT_W-1:0] f_idx;
    logic              out_free;

    assign out_free        = !r_out_valid || !i_out_stall;
    assign o_sts.out_free  = out_free;
    assign o_sts.scan_done = (r_idx == SLOT_W'(SLOTS - 1));
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

    // per-slot saturating age and time-out flags
    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            age_inc[j] = (r_age[j] == 16'hFFFF) ? r_age[j] : r_age[j] + 16'd1;
            fire[j]    = r_valid[j] && (age_inc[j] > r_interval);
        end
    end

    // any time-out above the scanned slot
    always_comb begin
        later_fire = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            if (fire[j] && (SLOT_W'(j) > r_idx)) begin
                later_fire = 1'b1;
            end
        end
    end

    // lowest matching slot and lowest free slot
    always_comb begin
        m_found = 1'b0;
        m_idx   = '0;
        f_found = 1'b0;
        f_idx   = '0;
        for (int j = SLOTS - 1; j >= 0; j--) begin
            if (r_valid[j] && (r_id[j] == i_in_data.message_id)) begin
                m_found = 1'b1;
                m_idx   = SLOT_W'(j);
            end
            if (!r_valid[j]) begin
                f_found = 1'b1;
                f_idx   = SLOT_W'(j);
            end
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval    <= RESET_INTERVAL;
            r_max_retries <= RESET_RETRIES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RETRY_INTERVAL: r_interval    <= i_cfg_data;
                REG_MAX_RETRIES:    r_max_retries <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_ctl.start) begin
            r_idx <= '0;
        end else if (i_ctl.step) begin
            r_idx <= o_sts.scan_done ? '0 : r_idx + SLOT_W'(1);
        end
    end

    // slot table and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_ctl.exec) begin
                case (i_in_data.cmd)
                    CMD_RECORD: begin
                        if (i_in_data.qos_level == 2'd1 || i_in_data.qos_level == 2'd2) begin
                            if (f_found) begin
                                r_valid[f_idx]   <= 1'b1;
                                r_id[f_idx]      <= i_in_data.message_id;
                                r_topic[f_idx]   <= i_in_data.topic;
                                r_qos[f_idx]     <= i_in_data.qos_level;
                                r_step[f_idx]    <= 1'b0;
                                r_retries[f_idx] <= 4'd0;
                                r_age[f_idx]     <= 16'd0;
                            end else begin
                                r_out_valid <= 1'b1;
                                r_out <= '{ACT_FULL, i_in_data.message_id,
                                           i_in_data.topic, i_in_data.qos_level,
                                           3'd0, 1'b1};
                            end
                        end
                    end
                    CMD_PUBACK, CMD_PUBCOMP: begin
                        if (m_found) begin
                            r_valid[m_idx] <= 1'b0;
                        end
                    end
                    CMD_PUBREC: begin
                        r_out_valid <= 1'b1;
                        r_out <= '{ACT_PUBREL, i_in_data.message_id, 16'd0,
                                   m_found ? r_qos[m_idx] : 2'd0,
                                   m_found ? 3'(m_idx) : 3'd0, 1'b1};
                        if (m_found) begin
                            r_step[m_idx] <= 1'b1;
                            r_age[m_idx]  <= 16'd0;
                        end
                    end
                    CMD_PUBREL: begin
                        r_out_valid <= 1'b1;
                        r_out <= '{ACT_PUBCOMP, i_in_data.message_id, 16'd0,
                                   m_found ? r_qos[m_idx] : 2'd0,
                                   m_found ? 3'(m_idx) : 3'd0, 1'b1};
                        if (m_found) begin
                            r_valid[m_idx] <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            // one slot of the tick scan
            if (i_ctl.step && r_valid[r_idx]) begin
                if (!fire[r_idx]) begin
                    r_age[r_idx] <= age_inc[r_idx];
                end else if (r_retries[r_idx] >= r_max_retries) begin
                    r_valid[r_idx] <= 1'b0;
                    r_out_valid    <= 1'b1;
                    r_out <= '{ACT_GAVE_UP, r_id[r_idx], r_topic[r_idx], r_qos[r_idx],
                               3'(r_idx), !later_fire};
                end else begin
                    r_out_valid <= 1'b1;
                    if (r_qos[r_idx] == 2'd2 && r_step[r_idx]) begin
                        r_out <= '{ACT_PUBREL, r_id[r_idx], 16'd0, r_qos[r_idx],
                                   3'(r_idx), !later_fire};
                    end else begin
                        r_out <= '{ACT_PUBLISH, r_id[r_idx], r_topic[r_idx], r_qos[r_idx],
                                   3'(r_idx), !later_fire};
                    end
                    if (r_retries[r_idx] != 4'd15) begin
                        r_retries[r_idx] <= r_retries[r_idx] + 4'd1;
                    end
                    r_age[r_idx] <= 16'd0;
                end
            end
        end
    end

    `QIRT_ASSERT_NXT(a_out_held, r_out_valid && i_out_stall, r_out_valid, "result lost under stall")
    `QIRT_ASSERT_NXT(a_valid_quiet, !i_ctl.exec && !i_ctl.step, $stable(r_valid), "slot table changed while idle")
    `QIRT_ASSERT_IMP(a_load_free, i_ctl.exec || i_ctl.step, out_free, "result register busy on load")

endmodule

FILE: sv/qos_inflight_retry_tracker.sv
// ---------------------------------------------------------------------------
// qos_inflight_retry_tracker
// table of outstanding qos 1 / qos 2 publishes with time-out retries
// ---------------------------------------------------------------------------
// Record and acknowledgement commands are accepted without a scan, and their
// single result, if any, is in the output register on the next cycle. A tick
// walks the slot table with a scan counter, one slot per cycle while the
// output side does not stall, and the input stays stalled until the scan is
// done; each timed-out slot gives one beat in slot order, the final beat of an
// item carries last. New items are taken only between scans and when the
// output register can load.
module qos_inflight_retry_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  qirt_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output qirt_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_we,
    input  logic [qirt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [qirt_pkg::CFG_W-1:0]    i_cfg_data
);
    import qirt_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // controller
    qirt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_in_data.cmd),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_ctl      (ctl)
    );

    // datapath
    qirt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
